// ===== src/sdspi_pkg.sv =====
// Shared types and constants for the SPI-mode SD command engine.
// Used by sdspi_step, sd_spi_command_engine and sdspi_checker; depends on nothing.
package sdspi_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int ADDR_SHIFT  = 9;
    localparam int PLAN_DEPTH  = 7;
    localparam int COUNT_W     = 10;
    localparam int STATUS_W    = 40;

    localparam logic [7:0] START_BITS   = 8'h40;
    localparam logic [7:0] CRC_CMD8     = 8'h87;
    localparam logic [7:0] CRC_OTHER    = 8'h95;
    localparam logic [7:0] POLL_BYTE    = 8'hFF;
    localparam logic [7:0] START_TOKEN  = 8'hFE;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RECEIVE = 1'b1;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_WAIT_R1 = 3'd1,
        PH_LONG    = 3'd2,
        PH_TOKEN   = 3'd3,
        PH_DATA    = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FRAME,
        ACT_POLL,
        ACT_FINISH,
        ACT_DATA_POLL,
        ACT_DATA_FINISH
    } action_t;

    typedef struct packed {
        phase_t                phase;
        logic                  want_long;
        logic                  want_data;
        logic [COUNT_W-1:0]    byte_count;
        logic [STATUS_W-1:0]   response_shift;
    } engine_state_t;

    typedef struct packed {
        logic        op;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic        long_response;
        logic        read_block;
        logic [7:0]  miso_byte;
    } request_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          mosi_byte;
        logic [STATUS_W-1:0] status;
        logic [7:0]          data_byte;
        logic                card_select;
        logic                last;
    } result_t;

endpackage

// ===== src/sd_spi_command_engine.sv =====
// A request's results wait in the plan register and move into the output register, one
// result per cycle unless the output stalls. A command request yields seven results, a
// received byte none, one or two, so requests flow back to back at that result rate.
// The result queue drains into the output register while the next request is taken.
// Reset (rst_n low, asynchronous) returns the engine to idle with no results pending.
// Depends on sdspi_pkg and sdspi_step.
module sd_spi_command_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [5:0]  cmd_index,
    input  logic [31:0] cmd_arg,
    input  logic        long_response,
    input  logic        read_block,
    input  logic [7:0]  miso_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  mosi_byte,
    output logic [7:0]  short_status,
    output logic [39:0] long_status,
    output logic [7:0]  data_byte,
    output logic        card_select,
    output logic        last
);

    sdspi_pkg::engine_state_t                       state_reg;
    sdspi_pkg::engine_state_t                       state_next;
    sdspi_pkg::request_t                            req;
    sdspi_pkg::result_t [sdspi_pkg::PLAN_DEPTH-1:0] step_plan;
    logic [2:0]                                     step_count;
    sdspi_pkg::result_t [sdspi_pkg::PLAN_DEPTH-1:0] plan_reg;
    sdspi_pkg::result_t [sdspi_pkg::PLAN_DEPTH-1:0] plan_next;
    logic [2:0]                                     plan_count_reg;
    logic [2:0]                                     plan_count_next;
    sdspi_pkg::result_t                             out_reg;
    logic                                           out_valid_reg;
    logic                                           move;
    logic                                           accept;

    assign req.op            = op;
    assign req.cmd_index     = cmd_index;
    assign req.cmd_arg       = cmd_arg;
    assign req.long_response = long_response;
    assign req.read_block    = read_block;
    assign req.miso_byte     = miso_byte;

    sdspi_step u_step (
        .state      (state_reg),
        .req        (req),
        .state_next (state_next),
        .plan       (step_plan),
        .plan_count (step_count)
    );

    assign move     = (plan_count_reg != 3'd0) && (!out_valid_reg || out_ready);
    assign in_ready = (plan_count_reg == 3'd0) || ((plan_count_reg == 3'd1) && move);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        plan_next       = plan_reg;
        plan_count_next = plan_count_reg;
        if (accept)
        begin
            plan_next       = step_plan;
            plan_count_next = step_count;
        end
        else if (move)
        begin
            for (int i = 0; i < sdspi_pkg::PLAN_DEPTH - 1; i++)
            begin
                plan_next[i] = plan_reg[i+1];
            end
            plan_next[sdspi_pkg::PLAN_DEPTH-1] = '0;
            plan_count_next = plan_count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            plan_count_reg <= 3'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            plan_count_reg <= plan_count_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        if (move)
        begin
            out_reg <= plan_reg[0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign mosi_byte    = out_reg.mosi_byte;
    assign short_status = out_reg.status[7:0];
    assign long_status  = out_reg.status;
    assign data_byte    = out_reg.data_byte;
    assign card_select  = out_reg.card_select;
    assign last         = out_reg.last;

endmodule

// ===== src/sdspi_step.sv =====
// Combinational step of the SPI-mode SD command engine: next state and result plan.
// Depends on sdspi_pkg.
module sdspi_step (
    input  sdspi_pkg::engine_state_t                     state,
    input  sdspi_pkg::request_t                          req,
    output sdspi_pkg::engine_state_t                     state_next,
    output sdspi_pkg::result_t [sdspi_pkg::PLAN_DEPTH-1:0] plan,
    output logic [2:0]                                   plan_count
);

    sdspi_pkg::action_t            action;
    logic [31:0]                   arg_word;
    logic [sdspi_pkg::COUNT_W:0]   count_plus;
    logic [sdspi_pkg::COUNT_W-1:0] count_inc;
    logic [7:0]                    crc_byte;

    assign arg_word   = req.read_block ? (req.cmd_arg << sdspi_pkg::ADDR_SHIFT) : req.cmd_arg;
    assign count_plus = {1'b0, state.byte_count} + (sdspi_pkg::COUNT_W+1)'(1);
    assign count_inc  = count_plus[sdspi_pkg::COUNT_W-1:0];
    assign crc_byte   = (req.cmd_index == sdspi_pkg::CMD_IF_COND) ?
                        sdspi_pkg::CRC_CMD8 : sdspi_pkg::CRC_OTHER;

    always_comb
    begin
        state_next = state;
        action     = sdspi_pkg::ACT_NONE;
        if (req.op == sdspi_pkg::OP_REQUEST)
        begin
            state_next.phase          = sdspi_pkg::PH_WAIT_R1;
            state_next.want_data      = req.read_block;
            state_next.want_long      = req.read_block ? 1'b0 : req.long_response;
            state_next.byte_count     = '0;
            state_next.response_shift = '0;
            action                    = sdspi_pkg::ACT_FRAME;
        end
        else
        begin
            unique case (state.phase)
                sdspi_pkg::PH_WAIT_R1:
                begin
                    if (req.miso_byte == sdspi_pkg::POLL_BYTE)
                    begin
                        action = sdspi_pkg::ACT_POLL;
                    end
                    else
                    begin
                        state_next.response_shift = {32'd0, req.miso_byte};
                        if (state.want_data)
                        begin
                            if (req.miso_byte != 8'd0)
                            begin
                                state_next.phase = sdspi_pkg::PH_IDLE;
                                action           = sdspi_pkg::ACT_FINISH;
                            end
                            else
                            begin
                                state_next.phase = sdspi_pkg::PH_TOKEN;
                                action           = sdspi_pkg::ACT_POLL;
                            end
                        end
                        else if (state.want_long)
                        begin
                            state_next.byte_count = sdspi_pkg::COUNT_W'(1);
                            state_next.phase      = sdspi_pkg::PH_LONG;
                            action                = sdspi_pkg::ACT_POLL;
                        end
                        else
                        begin
                            state_next.phase = sdspi_pkg::PH_IDLE;
                            action           = sdspi_pkg::ACT_FINISH;
                        end
                    end
                end
                sdspi_pkg::PH_LONG:
                begin
                    unique case (state.byte_count[2:0])
                        3'd0: state_next.response_shift[7:0]   = state.response_shift[7:0]
                                                                 | req.miso_byte;
                        3'd1: state_next.response_shift[15:8]  = state.response_shift[15:8]
                                                                 | req.miso_byte;
                        3'd2: state_next.response_shift[23:16] = state.response_shift[23:16]
                                                                 | req.miso_byte;
                        3'd3: state_next.response_shift[31:24] = state.response_shift[31:24]
                                                                 | req.miso_byte;
                        3'd4: state_next.response_shift[39:32] = state.response_shift[39:32]
                                                                 | req.miso_byte;
                        default: state_next.response_shift = state.response_shift;
                    endcase
                    state_next.byte_count = count_inc;
                    if (count_inc >= sdspi_pkg::COUNT_W'(5))
                    begin
                        state_next.phase = sdspi_pkg::PH_IDLE;
                        action           = sdspi_pkg::ACT_FINISH;
                    end
                    else
                    begin
                        action = sdspi_pkg::ACT_POLL;
                    end
                end
                sdspi_pkg::PH_TOKEN:
                begin
                    if (req.miso_byte == sdspi_pkg::START_TOKEN)
                    begin
                        state_next.phase      = sdspi_pkg::PH_DATA;
                        state_next.byte_count = '0;
                    end
                    action = sdspi_pkg::ACT_POLL;
                end
                sdspi_pkg::PH_DATA:
                begin
                    if (count_plus < (sdspi_pkg::COUNT_W+1)'(sdspi_pkg::BLOCK_BYTES))
                    begin
                        state_next.byte_count = count_inc;
                        action                = sdspi_pkg::ACT_DATA_POLL;
                    end
                    else
                    begin
                        state_next.byte_count = '0;
                        state_next.phase      = sdspi_pkg::PH_IDLE;
                        action                = sdspi_pkg::ACT_DATA_FINISH;
                    end
                end
                default:
                begin
                    state_next.phase = sdspi_pkg::PH_IDLE;
                    action           = sdspi_pkg::ACT_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        sdspi_pkg::result_t send_poll;
        sdspi_pkg::result_t done;
        sdspi_pkg::result_t data;

        send_poll             = '0;
        send_poll.kind        = sdspi_pkg::KIND_SEND;
        send_poll.mosi_byte   = sdspi_pkg::POLL_BYTE;
        send_poll.card_select = 1'b1;
        send_poll.last        = 1'b1;

        done        = '0;
        done.kind   = sdspi_pkg::KIND_DONE;
        done.status = state_next.response_shift;
        done.last   = 1'b1;

        data             = '0;
        data.kind        = sdspi_pkg::KIND_DATA;
        data.data_byte   = req.miso_byte;
        data.card_select = 1'b1;

        plan       = '0;
        plan_count = 3'd0;
        unique case (action)
            sdspi_pkg::ACT_FRAME:
            begin
                for (int i = 0; i < sdspi_pkg::PLAN_DEPTH; i++)
                begin
                    plan[i]             = send_poll;
                    plan[i].last        = 1'b0;
                end
                plan[0].mosi_byte = sdspi_pkg::START_BITS | {2'b00, req.cmd_index};
                plan[1].mosi_byte = arg_word[31:24];
                plan[2].mosi_byte = arg_word[23:16];
                plan[3].mosi_byte = arg_word[15:8];
                plan[4].mosi_byte = arg_word[7:0];
                plan[5].mosi_byte = crc_byte;
                plan[6].last      = 1'b1;
                plan_count        = 3'd7;
            end
            sdspi_pkg::ACT_POLL:
            begin
                plan[0]    = send_poll;
                plan_count = 3'd1;
            end
            sdspi_pkg::ACT_FINISH:
            begin
                plan[0]    = done;
                plan_count = 3'd1;
            end
            sdspi_pkg::ACT_DATA_POLL:
            begin
                plan[0]    = data;
                plan[1]    = send_poll;
                plan_count = 3'd2;
            end
            sdspi_pkg::ACT_DATA_FINISH:
            begin
                plan[0]    = data;
                plan[1]    = done;
                plan_count = 3'd2;
            end
            default:
            begin
                plan_count = 3'd0;
            end
        endcase
    end

endmodule

// ===== src/sdspi_checker.sv =====
// Port-level checks for the SPI-mode SD command engine, bound to the top level.
// Depends on sdspi_pkg and sd_spi_command_engine.
module sdspi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  mosi_byte,
    input logic [7:0]  short_status,
    input logic [39:0] long_status,
    input logic [7:0]  data_byte,
    input logic        card_select,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(mosi_byte)
            && $stable(long_status) && $stable(data_byte) && $stable(last))
        else $error("Stalled result changed before it was taken.");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != sdspi_pkg::KIND_NONE)
        else $error("Result carries an unused kind code.");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sdspi_pkg::KIND_DONE |->
            last && !card_select && short_status == long_status[7:0])
        else $error("Response-complete result is malformed.");

    a_data_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sdspi_pkg::KIND_DATA |-> !last && card_select && mosi_byte == 8'd0)
        else $error("Data result is malformed.");

    a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sdspi_pkg::KIND_SEND |->
            card_select && long_status == 40'd0 && data_byte == 8'd0)
        else $error("Send result carries stray fields.");

endmodule

bind sd_spi_command_engine sdspi_checker u_checker (.*);
